### rtl/nca_pkg.sv
// ----------------------------------------------------------------------------
// nca_pkg
// Shared types and constants for the nearest-centre assignment block.
// ----------------------------------------------------------------------------
package nca_pkg;

    localparam int CFG_W   = 7;    // width of the num_centers / dimension registers
    localparam int CNT_W   = 7;    // coordinate counter, saturating
    localparam int IDX_W   = 6;    // centre index and coordinate index on the ports
    localparam int ACC_W   = 38;   // distance accumulator, unsigned Q38.0

    localparam logic [ACC_W-1:0] ACC_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [0:0] {
        CFG_NUM_CENTERS = 1'b0,
        CFG_DIMENSION   = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_FRAME = 1'b1
    } cmd_t;

    // control part of an item travelling down the cell chain
    typedef struct packed {
        logic             valid;
        logic             frame;    // frame coordinate, else centre load
        logic             wr_ok;    // load address inside the table
        logic             sum_en;   // coordinate falls inside dimension
        logic             eof;
        logic             err;      // length mismatch, valid with eof
        logic [IDX_W-1:0] cidx;
    } tok_ctl_t;

endpackage

### rtl/nearest_center_assign_top.sv
// ----------------------------------------------------------------------------
// nearest_center_assign_top
// Nearest-centre assignment (k-means, squared Euclidean) over a chain of
// centre cells.
// ----------------------------------------------------------------------------
// Usage:
//   Configure num_centers (index 0) and dimension (index 1) on the cfg
//   channel while the block is idle; cfg_ready is always high.
//   Item channel (item_valid / item_stall): command 0 loads one centre
//   coordinate, command 1 streams the next frame coordinate. An item with
//   end_of_frame set on a frame coordinate produces one result on the
//   result channel (result_valid / result_stall); other items produce none.
//   One item is taken per cycle while item_stall is low. Each item walks
//   the chain of MAX_CENTERS cells, three register stages per cell (table
//   read, square, accumulate and compare), and an end-of-frame item then
//   loads the result register at the end of the chain.
//   When a result waits and result_stall is high the whole chain freezes and
//   item_stall goes high; nothing is dropped.
//   Reset clears the accumulators, the coordinate counter and the result
//   valid flag, and sets both config registers to 1. The centre table is not
//   cleared: centres must be loaded before they are used.
// ----------------------------------------------------------------------------
module nearest_center_assign_top #(
    parameter int MAX_CENTERS = 64,
    parameter int MAX_DIM     = 64,
    parameter int COORD_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [0:0]                       cfg_index,
    input  logic [nca_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic                             command,
    input  logic [nca_pkg::IDX_W-1:0]        center_index,
    input  logic [nca_pkg::IDX_W-1:0]        coord_index,
    input  logic signed [COORD_BITS-1:0]     coord_value,
    input  logic                             end_of_frame,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [nca_pkg::IDX_W-1:0]        nearest_center,
    output logic [nca_pkg::ACC_W-1:0]        min_sq_distance,
    output logic                             length_error
);
    import nca_pkg::*;

    localparam int AW = $clog2(MAX_DIM > 1 ? MAX_DIM : 2);
    localparam int IW = $clog2(MAX_CENTERS > 1 ? MAX_CENTERS : 2);

    logic [CFG_W-1:0] num_centers_reg;
    logic [CFG_W-1:0] dimension_reg;
    logic [CFG_W-1:0] dim_eff;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_inc;
    logic             adv;
    logic             accept;
    logic             is_frame;

    tok_ctl_t                     ctl   [MAX_CENTERS+1];
    logic [AW-1:0]                addr  [MAX_CENTERS+1];
    logic signed [COORD_BITS-1:0] value [MAX_CENTERS+1];
    logic [IW-1:0]                bidx  [MAX_CENTERS+1];
    logic [ACC_W-1:0]             bd    [MAX_CENTERS+1];

    assign cfg_ready  = 1'b1;
    assign item_stall = !adv;
    assign accept     = item_valid && adv;
    assign is_frame   = (command == CMD_FRAME);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_centers_reg <= CFG_W'(1);
            dimension_reg   <= CFG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_NUM_CENTERS: num_centers_reg <= cfg_data;
                CFG_DIMENSION:   dimension_reg   <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        priority if (dimension_reg == '0)
        begin
            dim_eff = CFG_W'(1);
        end
        else if (int'(dimension_reg) > MAX_DIM)
        begin
            dim_eff = CFG_W'(MAX_DIM);
        end
        else
        begin
            dim_eff = dimension_reg;
        end
    end

    assign cnt_inc = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (accept && is_frame)
        begin
            cnt_reg <= end_of_frame ? '0 : cnt_inc;
        end
    end

    // item entering the first cell
    always_comb
    begin
        ctl[0].valid  = item_valid;
        ctl[0].frame  = is_frame;
        ctl[0].wr_ok  = (int'(coord_index) < MAX_DIM) && (int'(center_index) < MAX_CENTERS);
        ctl[0].sum_en = is_frame && (cnt_reg < dim_eff);
        ctl[0].eof    = end_of_frame;
        ctl[0].err    = (cnt_inc != dim_eff);
        ctl[0].cidx   = center_index;
        addr[0]       = is_frame ? AW'(cnt_reg) : AW'(coord_index);
        value[0]      = coord_value;
        bidx[0]       = '0;
        bd[0]         = '0;
    end

    for (genvar g = 0; g < MAX_CENTERS; g++)
    begin : g_cell
        nca_cell #(
            .MY_INDEX    (g),
            .MAX_CENTERS (MAX_CENTERS),
            .MAX_DIM     (MAX_DIM),
            .COORD_BITS  (COORD_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .adv          (adv),
            .num_centers  (num_centers_reg),
            .in_ctl       (ctl[g]),
            .in_addr      (addr[g]),
            .in_value     (value[g]),
            .in_best_idx  (bidx[g]),
            .in_best_d    (bd[g]),
            .out_ctl      (ctl[g+1]),
            .out_addr     (addr[g+1]),
            .out_value    (value[g+1]),
            .out_best_idx (bidx[g+1]),
            .out_best_d   (bd[g+1])
        );
    end

    nca_outreg #(
        .MAX_CENTERS (MAX_CENTERS)
    ) u_outreg (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ctl          (ctl[MAX_CENTERS]),
        .in_best_idx     (bidx[MAX_CENTERS]),
        .in_best_d       (bd[MAX_CENTERS]),
        .result_stall    (result_stall),
        .adv             (adv),
        .result_valid    (result_valid),
        .nearest_center  (nearest_center),
        .min_sq_distance (min_sq_distance),
        .length_error    (length_error)
    );

endmodule

### rtl/nca_cell.sv
// ----------------------------------------------------------------------------
// nca_cell
// One centre of the chain: holds its coordinates and its running squared
// distance, and passes the item and the running best on to its neighbour.
// ----------------------------------------------------------------------------
module nca_cell #(
    parameter int MY_INDEX    = 0,
    parameter int MAX_CENTERS = 64,
    parameter int MAX_DIM     = 64,
    parameter int COORD_BITS  = 16
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              adv,
    input  logic [nca_pkg::CFG_W-1:0]                         num_centers,
    input  nca_pkg::tok_ctl_t                                 in_ctl,
    input  logic [$clog2(MAX_DIM > 1 ? MAX_DIM : 2)-1:0]      in_addr,
    input  logic signed [COORD_BITS-1:0]                      in_value,
    input  logic [$clog2(MAX_CENTERS > 1 ? MAX_CENTERS : 2)-1:0] in_best_idx,
    input  logic [nca_pkg::ACC_W-1:0]                         in_best_d,
    output nca_pkg::tok_ctl_t                                 out_ctl,
    output logic [$clog2(MAX_DIM > 1 ? MAX_DIM : 2)-1:0]      out_addr,
    output logic signed [COORD_BITS-1:0]                      out_value,
    output logic [$clog2(MAX_CENTERS > 1 ? MAX_CENTERS : 2)-1:0] out_best_idx,
    output logic [nca_pkg::ACC_W-1:0]                         out_best_d
);
    import nca_pkg::*;

    localparam int AW = $clog2(MAX_DIM > 1 ? MAX_DIM : 2);
    localparam int IW = $clog2(MAX_CENTERS > 1 ? MAX_CENTERS : 2);
    localparam int DW = COORD_BITS + 1;
    localparam int CW = (DW > 32) ? 32 : DW;
    localparam int PW = 2 * CW;
    localparam int SW = ((PW > ACC_W) ? PW : ACC_W) + 1;

    logic [COORD_BITS-1:0] mem [MAX_DIM];

    // stage 1: table read
    tok_ctl_t                    ctl1_reg;
    logic [AW-1:0]               addr1_reg;
    logic signed [COORD_BITS-1:0] val1_reg;
    logic signed [COORD_BITS-1:0] rd_reg;
    logic [IW-1:0]               bidx1_reg;
    logic [ACC_W-1:0]            bd1_reg;
    // stage 2: square
    tok_ctl_t                    ctl2_reg;
    logic [AW-1:0]               addr2_reg;
    logic signed [COORD_BITS-1:0] val2_reg;
    logic [PW-1:0]               prod_reg;
    logic [IW-1:0]               bidx2_reg;
    logic [ACC_W-1:0]            bd2_reg;
    // stage 3: accumulate and compare
    tok_ctl_t                    ctl3_reg;
    logic [AW-1:0]               addr3_reg;
    logic signed [COORD_BITS-1:0] val3_reg;
    logic [IW-1:0]               bidx3_reg;
    logic [ACC_W-1:0]            bd3_reg;

    logic [ACC_W-1:0]            acc_reg;
    logic [ACC_W-1:0]            acc_next;

    logic                        wr_en;
    logic signed [DW-1:0]        diff;
    logic [DW-1:0]               mag;
    logic [32:0]                 mag_ext;
    logic [CW-1:0]               cmag;
    logic [PW-1:0]               prod_next;
    logic [SW-1:0]               sum;
    logic                        active;
    logic                        upd;
    logic                        take;

    assign wr_en = adv && in_ctl.valid && !in_ctl.frame && in_ctl.wr_ok
                   && (int'(in_ctl.cidx) == MY_INDEX);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[in_addr] <= in_value;
        end
        if (adv)
        begin
            rd_reg <= $signed(mem[in_addr]);
        end
    end

    // difference magnitude, clamped to 32 bits, then squared
    always_comb
    begin
        diff = DW'(val1_reg) - DW'(rd_reg);
        mag  = diff[DW-1] ? unsigned'(~diff + 1'b1) : unsigned'(diff);
        mag_ext = 33'(mag);
        cmag = (mag_ext > 33'h0_FFFF_FFFF) ? '1 : CW'(mag_ext);
        prod_next = PW'(cmag) * PW'(cmag);
    end

    assign active = (MY_INDEX == 0) || (MY_INDEX < int'(num_centers));
    assign upd    = ctl2_reg.valid && ctl2_reg.frame && ctl2_reg.sum_en && active;

    always_comb
    begin
        sum      = SW'(acc_reg) + SW'(prod_reg);
        acc_next = acc_reg;
        if (upd)
        begin
            acc_next = (sum > SW'(ACC_MAX)) ? ACC_MAX : ACC_W'(sum);
        end
        // strict less-than keeps the lower index on ties
        take = ctl2_reg.valid && ctl2_reg.frame && ctl2_reg.eof && active
               && ((MY_INDEX == 0) || (acc_next < bd2_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            acc_reg  <= '0;
        end
        else if (adv)
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            if (ctl2_reg.valid && ctl2_reg.frame)
            begin
                acc_reg <= ctl2_reg.eof ? '0 : acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            addr1_reg <= in_addr;
            val1_reg  <= in_value;
            bidx1_reg <= in_best_idx;
            bd1_reg   <= in_best_d;
            addr2_reg <= addr1_reg;
            val2_reg  <= val1_reg;
            prod_reg  <= prod_next;
            bidx2_reg <= bidx1_reg;
            bd2_reg   <= bd1_reg;
            addr3_reg <= addr2_reg;
            val3_reg  <= val2_reg;
            bidx3_reg <= take ? IW'(MY_INDEX) : bidx2_reg;
            bd3_reg   <= take ? acc_next : bd2_reg;
        end
    end

    assign out_ctl      = ctl3_reg;
    assign out_addr     = addr3_reg;
    assign out_value    = val3_reg;
    assign out_best_idx = bidx3_reg;
    assign out_best_d   = bd3_reg;

endmodule

### rtl/nca_outreg.sv
// ----------------------------------------------------------------------------
// nca_outreg
// Result register at the end of the chain; derives the chain advance from
// the result stall.
// ----------------------------------------------------------------------------
module nca_outreg #(
    parameter int MAX_CENTERS = 64
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  nca_pkg::tok_ctl_t                                    in_ctl,
    input  logic [$clog2(MAX_CENTERS > 1 ? MAX_CENTERS : 2)-1:0] in_best_idx,
    input  logic [nca_pkg::ACC_W-1:0]                            in_best_d,
    input  logic                                                 result_stall,
    output logic                                                 adv,
    output logic                                                 result_valid,
    output logic [nca_pkg::IDX_W-1:0]                            nearest_center,
    output logic [nca_pkg::ACC_W-1:0]                            min_sq_distance,
    output logic                                                 length_error
);
    import nca_pkg::*;

    logic             valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [ACC_W-1:0] dist_reg;
    logic             err_reg;
    logic             load;

    assign adv  = !valid_reg || !result_stall;
    assign load = in_ctl.valid && in_ctl.frame && in_ctl.eof;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && load)
        begin
            idx_reg  <= IDX_W'(in_best_idx);
            dist_reg <= in_best_d;
            err_reg  <= in_ctl.err;
        end
    end

    assign result_valid    = valid_reg;
    assign nearest_center  = idx_reg;
    assign min_sq_distance = dist_reg;
    assign length_error    = err_reg;

endmodule

### rtl/nca_checker.sv
// ----------------------------------------------------------------------------
// nca_checker
// Port-level checks on the nearest-centre assignment block, bound to the top.
// ----------------------------------------------------------------------------
module nca_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [0:0]  cfg_index,
    input logic [6:0]  cfg_data,
    input logic        item_valid,
    input logic        item_stall,
    input logic        command,
    input logic [5:0]  center_index,
    input logic [5:0]  coord_index,
    input logic [15:0] coord_value,
    input logic        end_of_frame,
    input logic        result_valid,
    input logic        result_stall,
    input logic [5:0]  nearest_center,
    input logic [37:0] min_sq_distance,
    input logic        length_error
);

    // a held result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(nearest_center)
        && $stable(min_sq_distance) && $stable(length_error))
        else $error("result changed while stalled");

    // the input only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("item stall without a stalled result");

    // a new result is only loaded on a cycle the chain advanced
    a_rise_adv: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_stall))
        else $error("result appeared while chain was frozen");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind nearest_center_assign_top nca_checker u_nca_checker (.*);
